>>> hdl/fill_first_token_router_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fill-first token router.
// Each macro expects signals named clk and rst in the scope of its use.
// ----------------------------------------------------------------------------
`ifndef FILL_FIRST_TOKEN_ROUTER_MACROS_SVH
`define FILL_FIRST_TOKEN_ROUTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FFTR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FFTR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/fftr_pkg.sv
// ----------------------------------------------------------------------------
// fftr_pkg
// Constants, codes and types shared by the fill-first token router modules.
// ----------------------------------------------------------------------------
package fftr_pkg;

  // Store dimensions.
  localparam int NUM_RECEIVERS = 16;
  localparam int MAX_TOKENS    = 64;

  // Field widths.
  localparam int RID_W  = 4;
  localparam int TOK_W  = 7;
  localparam int PCT_W  = 7;
  localparam int SEQ_W  = 64;
  localparam int PROD_W = TOK_W + PCT_W;

  // Quota arithmetic: (total * percent + bias) / divisor.
  localparam int QUOTA_DIVISOR = 100;
  localparam int QUOTA_BIAS    = 99;
  // The division is a multiplication by ceil(2^19 / 100) and a shift by 19,
  // which is exact for every biased product that fits in PROD_W bits.
  localparam int QUOTA_RECIP   = 5243;
  localparam int QUOTA_SHIFT   = 19;
  localparam int RECIP_W       = 13;
  localparam int MUL_W         = PROD_W + RECIP_W;
  localparam int QUOTA_STEPS   = 2;
  localparam int STEP_W        = $clog2(QUOTA_STEPS);

  // Register reset value.
  localparam logic [PCT_W-1:0] PCT_RESET = PCT_W'(50);

  // Action codes of an input item.
  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_BUILD = 1'b1;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QUOTA,
    ST_SCAN,
    ST_EMPTY
  } fftr_state_t;

  // Status of the quota unit.
  typedef struct packed {
    logic busy;
    logic done;
  } fftr_qstat_t;

endpackage

>>> hdl/fill_first_token_router.sv
// An add item is taken in the idle state; a build on an empty store goes to
// the empty state. Any other build is accepted, passes through the quota unit,
// then walks the receivers, one entry per token, passing over empty ones.
// The input takes one item at a time and is stalled until the build ends.
// Reset (rst, synchronous) clears the token counts, the total and the sequence
// number, and sets the usage percentage to 50.
// ----------------------------------------------------------------------------
// fill_first_token_router
// Counts free tokens per receiver and, on a build, hands out a quota of them
// starting at the lowest receiver id, one routing entry per token.
// ----------------------------------------------------------------------------
`include "fill_first_token_router_macros.svh"

module fill_first_token_router (
  input  logic                       clk,
  input  logic                       rst,
  // Configuration write channel.
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [fftr_pkg::PCT_W-1:0] usage_percent,
  // Input channel.
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       action,
  input  logic [fftr_pkg::RID_W-1:0] receiver,
  // Output channel.
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [fftr_pkg::SEQ_W-1:0] sequence_id,
  output logic [fftr_pkg::RID_W-1:0] target,
  output logic                       last,
  output logic                       empty_res
);
  import fftr_pkg::*;

  fftr_state_t        state;
  fftr_state_t        state_next;
  logic [PCT_W-1:0]   percent;
  logic [TOK_W-1:0]   tokens [NUM_RECEIVERS];
  logic [TOK_W-1:0]   total;
  logic [SEQ_W-1:0]   next_sequence;
  logic [TOK_W-1:0]   count;
  logic [RID_W-1:0]   scan;
  logic [TOK_W-1:0]   cur_tokens;
  logic               in_accept;
  logic               out_free;
  logic               add_ok;
  logic               start_q;
  logic               emit;
  logic               skip;
  logic               load_empty;
  fftr_qstat_t        qstat;
  logic [TOK_W-1:0]   quota;

  // Quota unit.
  fftr_quota u_quota (
    .clk     (clk),
    .rst     (rst),
    .start   (start_q),
    .total   (total),
    .percent (percent),
    .status  (qstat),
    .quota   (quota)
  );

  assign cfg_ready  = 1'b1;
  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign cur_tokens = tokens[scan];

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && (action == ACT_BUILD)) begin
          state_next = (total == '0) ? ST_EMPTY : ST_QUOTA;
        end
      end
      ST_QUOTA: begin
        if (qstat.done) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((cur_tokens != '0) && out_free && (count == TOK_W'(1))) begin
          state_next = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall   = 1'b1;
    add_ok     = 1'b0;
    start_q    = 1'b0;
    emit       = 1'b0;
    skip       = 1'b0;
    load_empty = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        add_ok   = in_valid && (action == ACT_ADD) &&
                   ((RID_W + 1)'(receiver) < (RID_W + 1)'(NUM_RECEIVERS)) &&
                   ((TOK_W + 1)'(total) < (TOK_W + 1)'(MAX_TOKENS));
        start_q  = in_valid && (action == ACT_BUILD) && (total != '0);
      end
      ST_QUOTA: begin
      end
      ST_SCAN: begin
        skip = (cur_tokens == '0);
        emit = (cur_tokens != '0) && out_free;
      end
      ST_EMPTY: begin
        load_empty = out_free;
      end
      default: begin
      end
    endcase
  end

  // State register and configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      percent <= PCT_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        percent <= usage_percent;
      end
    end
  end

  // Token store, totals and sequence number.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_RECEIVERS; i++) begin
        tokens[i] <= '0;
      end
      total         <= '0;
      next_sequence <= '0;
    end else begin
      if (add_ok) begin
        tokens[receiver] <= tokens[receiver] + TOK_W'(1);
        total            <= total + TOK_W'(1);
      end else if (emit) begin
        tokens[scan]  <= cur_tokens - TOK_W'(1);
        total         <= total - TOK_W'(1);
        next_sequence <= next_sequence + SEQ_W'(1);
      end
    end
  end

  // Walk position and tokens still to hand out in this build.
  always_ff @(posedge clk) begin
    if (qstat.done) begin
      count <= quota;
      scan  <= '0;
    end else if (skip) begin
      scan <= scan + RID_W'(1);
    end else if (emit) begin
      count <= count - TOK_W'(1);
    end
  end

  // Output register: holds one item until the receiving side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit || load_empty) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      sequence_id <= next_sequence;
      target      <= scan;
      last        <= (count == TOK_W'(1));
      empty_res   <= 1'b0;
    end else if (load_empty) begin
      sequence_id <= '0;
      target      <= '0;
      last        <= 1'b1;
      empty_res   <= 1'b1;
    end
  end

  `FFTR_ASSERT_IMP(a_count_le_total, state == ST_SCAN, (count != '0) && (count <= total), "walk count exceeds store")
  `FFTR_ASSERT_NEXT(a_full_drop, in_accept && (action == ACT_ADD) && ((TOK_W + 1)'(total) >= (TOK_W + 1)'(MAX_TOKENS)), $stable(total), "add into full store changed total")
  `FFTR_ASSERT_IMP(a_seq_follow, out_valid && !empty_res, (sequence_id + SEQ_W'(1)) == next_sequence, "sequence number out of step")
  `FFTR_ASSERT_IMP(a_empty_last, out_valid && empty_res, last, "empty item without last")

endmodule

>>> hdl/fftr_quota.sv
// ----------------------------------------------------------------------------
// fftr_quota
// Works out the build quota with one shared multiplier used in two passes:
// first the product of total and percent, then a reciprocal multiplication
// for the division. The result is clamped to the range one to total.
// ----------------------------------------------------------------------------
`include "fill_first_token_router_macros.svh"

module fftr_quota (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [fftr_pkg::TOK_W-1:0] total,
  input  logic [fftr_pkg::PCT_W-1:0] percent,
  output fftr_pkg::fftr_qstat_t      status,
  output logic [fftr_pkg::TOK_W-1:0] quota
);
  import fftr_pkg::*;

  logic                active;
  logic                done;
  logic [STEP_W-1:0]   step;
  logic [PROD_W-1:0]   rem;
  logic [TOK_W-1:0]    quot;
  logic [TOK_W-1:0]    total_l;
  logic [PCT_W-1:0]    percent_l;
  logic                first;
  logic [PROD_W-1:0]   mul_a;
  logic [RECIP_W-1:0]  mul_b;
  logic [MUL_W-1:0]    mul_p;

  // Shared multiplier: the first pass forms total * percent, the second
  // scales the biased product by the reciprocal of the divisor.
  assign first = (step != '0);
  assign mul_a = first ? PROD_W'(total_l) : rem;
  assign mul_b = first ? RECIP_W'(percent_l) : RECIP_W'(QUOTA_RECIP);
  assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

  // Control: stay active through both passes, then flag completion.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
      end else if (active && (step == '0)) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  // Datapath: capture the operands, add the bias, then take the quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      quot      <= '0;
      step      <= STEP_W'(QUOTA_STEPS - 1);
      total_l   <= total;
      percent_l <= percent;
    end else if (active) begin
      if (first) begin
        rem <= PROD_W'(mul_p) + PROD_W'(QUOTA_BIAS);
      end else begin
        quot <= mul_p[QUOTA_SHIFT +: TOK_W];
      end
      step <= step - STEP_W'(1);
    end
  end

  // Clamp: at least one token, never more than the store holds.
  always_comb begin
    if (quot == '0) begin
      quota = TOK_W'(1);
    end else if (quot > total_l) begin
      quota = total_l;
    end else begin
      quota = quot;
    end
  end

  assign status.busy = active;
  assign status.done = done;

  `FFTR_ASSERT_IMP(a_quota_range, done, (quota != '0) && (quota <= total_l), "quota out of range")
  `FFTR_ASSERT_NEXT(a_no_restart, active && !start, active || done, "quota unit stopped early")

endmodule
